// ===== hw/rtl/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// mps_pkg - shared types and constants for the masked pattern scanner
// Register indexes, field widths and the compare configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

   // configuration port geometry
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_BYTES  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CARE_MASK      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LENGTH = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_OFFSET   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_ONLY     = 3'd4;

   // field widths
   localparam int BYTE_BITS   = 8;
   localparam int LEN_BITS    = 4;
   localparam int FIELD_BITS  = 24;

   // candidate starts sit at even distance from the restart point
   localparam int ALIGN_STEP = 2;
   localparam int ALIGN_MASK = ALIGN_STEP - 1;

   // pattern and per-bit care mask, byte k in bits 8k+7..8k
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] pattern_bytes;
      logic [CSR_DATA_BITS-1:0] care_mask;
   } cmp_cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mps_window_match.sv =====
// ----------------------------------------------------------------------------
// mps_window_match - masked compare of the byte window against the pattern
// Pattern byte k is compared with the byte that arrived (length-1-k) beats
// ago; only bits under the care mask take part.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_window_match
   import mps_pkg::*;
#(
   parameter int MAX_PATTERN = 8
) (
   input  wire logic [MAX_PATTERN*BYTE_BITS-1:0] window,
   input  wire cmp_cfg_type                      cmp_cfg,
   input  wire logic [LEN_BITS-1:0]              active_length,
   output logic                                  window_hit
);

   // pick the aged byte for each pattern slot and check it under the mask
   always_comb begin
      logic [BYTE_BITS-1:0] got;
      window_hit = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         got = '0;
         for (int a = 0; a < MAX_PATTERN; a++) begin
            if (a == int'(active_length) - 1 - k) begin
               got = window[BYTE_BITS*a +: BYTE_BITS];
            end
         end
         if (k < int'(active_length)) begin
            if (((got ^ cmp_cfg.pattern_bytes[BYTE_BITS*k +: BYTE_BITS])
                 & cmp_cfg.care_mask[BYTE_BITS*k +: BYTE_BITS]) != '0) begin
               window_hit = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/masked_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// masked_pattern_scanner_unit - masked byte pattern search over an image
// Scans a byte stream for a masked pattern and reports match offsets.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one image byte per beat, req_last_byte on the final byte.
//   rsp_ channel: one beat per reported match (rsp_end_of_scan = 0), and a
//   closing beat after the final byte (rsp_end_of_scan = 1, offset 0) that
//   carries the match count. Bytes that produce nothing give no rsp_ beat.
//   csr_ port: write pattern, care mask, length, start offset and first-only
//   while the block is idle; there is no read-back.
// Timing:
//   One byte is taken every cycle while req_ready is high. A result appears in
//   the output register in the cycle after the byte that causes it; that register
//   is the only stage. The window compare, candidate checks and counter update
//   all settle between the input handshake and this register.
// Stall and reset:
//   While a result waits and rsp_ready is low, req_ready drops; a byte is
//   still taken in the cycle the waiting result is taken. Reset clears the
//   scan state and loads the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_pattern_scanner_unit
   import mps_pkg::*;
#(
   parameter int MAX_PATTERN = 8,
   parameter int OFFSET_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // image byte channel
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [BYTE_BITS-1:0]      req_data_byte,
   input  wire logic                      req_last_byte,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [FIELD_BITS-1:0]          rsp_match_offset,
   output logic                           rsp_end_of_scan,
   output logic [FIELD_BITS-1:0]          rsp_match_count,
   // configuration port
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int WIN_BITS = MAX_PATTERN * BYTE_BITS;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_bytes_ff;
   logic [CSR_DATA_BITS-1:0] care_mask_ff;
   logic [LEN_BITS-1:0]      pattern_length_ff;
   logic [FIELD_BITS-1:0]    start_offset_ff;
   logic                     first_only_ff;

   // scan state
   logic [WIN_BITS-1:0]      window_ff,         window_in;
   logic [OFFSET_BITS-1:0]   byte_position_ff,  byte_position_in;
   logic [OFFSET_BITS-1:0]   next_candidate_ff, next_candidate_in;
   logic [FIELD_BITS-1:0]    found_total_ff,    found_total_in;
   logic                     scan_stopped_ff,   scan_stopped_in;

   // result register
   logic                     rsp_valid_ff,      rsp_valid_in;
   logic [FIELD_BITS-1:0]    rsp_offset_ff,     rsp_offset_in;
   logic                     rsp_end_ff,        rsp_end_in;
   logic [FIELD_BITS-1:0]    rsp_count_ff,      rsp_count_in;

   logic                     req_accept;
   logic [WIN_BITS-1:0]      window_shifted;
   logic [LEN_BITS-1:0]      active_length;
   logic [OFFSET_BITS-1:0]   length_ext;
   logic [OFFSET_BITS-1:0]   cand_start;
   logic                     window_hit;
   logic                     cand_hit;
   logic                     match_report;
   logic [FIELD_BITS-1:0]    found_bumped;
   cmp_cfg_type              cmp_cfg;

   // handshake: the output register parts the two sides
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         care_mask_ff      <= '1;
         pattern_length_ff <= LEN_BITS'(8);
         start_offset_ff   <= '0;
         first_only_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:  pattern_bytes_ff  <= csr_write_data;
            CSR_CARE_MASK:      care_mask_ff      <= csr_write_data;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[LEN_BITS-1:0];
            CSR_START_OFFSET:   start_offset_ff   <= csr_write_data[FIELD_BITS-1:0];
            CSR_FIRST_ONLY:     first_only_ff     <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // clamp the pattern length to 1..MAX_PATTERN
   always_comb begin
      priority if (pattern_length_ff == '0) begin
         active_length = LEN_BITS'(1);
      end else if (pattern_length_ff > LEN_BITS'(MAX_PATTERN)) begin
         active_length = LEN_BITS'(MAX_PATTERN);
      end else begin
         active_length = pattern_length_ff;
      end
   end

   // shift the new byte in at age zero
   always_comb begin
      window_shifted[BYTE_BITS-1:0] = req_data_byte;
      for (int a = 1; a < MAX_PATTERN; a++) begin
         window_shifted[BYTE_BITS*a +: BYTE_BITS] = window_ff[BYTE_BITS*(a-1) +: BYTE_BITS];
      end
   end

   assign cmp_cfg.pattern_bytes = pattern_bytes_ff;
   assign cmp_cfg.care_mask     = care_mask_ff;

   mps_window_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .window        (window_shifted),
      .cmp_cfg       (cmp_cfg),
      .active_length (active_length),
      .window_hit    (window_hit)
   );

   // candidate start and its qualification
   assign length_ext = OFFSET_BITS'(active_length);
   assign cand_start = byte_position_ff - (length_ext - OFFSET_BITS'(1));

   assign cand_hit = !req_last_byte && !scan_stopped_ff
                  && (byte_position_ff >= length_ext - OFFSET_BITS'(1))
                  && (cand_start >= next_candidate_ff)
                  && (((cand_start ^ next_candidate_ff) & OFFSET_BITS'(ALIGN_MASK)) == '0)
                  && window_hit;
   assign match_report = cand_hit && (cand_start != '0);

   // saturating match count
   assign found_bumped = (found_total_ff == '1) ? found_total_ff
                                                : found_total_ff + FIELD_BITS'(1);

   // next scan state
   always_comb begin
      window_in         = window_ff;
      byte_position_in  = byte_position_ff;
      next_candidate_in = next_candidate_ff;
      found_total_in    = found_total_ff;
      scan_stopped_in   = scan_stopped_ff;

      // start offset takes effect at once before the first byte of an image
      if (csr_write_enable && csr_index == CSR_START_OFFSET && byte_position_ff == '0) begin
         next_candidate_in = OFFSET_BITS'(csr_write_data[FIELD_BITS-1:0]);
      end

      if (req_accept) begin
         if (req_last_byte) begin
            // restart for the next image
            window_in         = '0;
            byte_position_in  = '0;
            next_candidate_in = OFFSET_BITS'(start_offset_ff);
            found_total_in    = '0;
            scan_stopped_in   = 1'b0;
         end else begin
            window_in        = window_shifted;
            byte_position_in = byte_position_ff + OFFSET_BITS'(1);
            if (cand_hit) begin
               next_candidate_in = cand_start + length_ext;
            end
            if (match_report) begin
               found_total_in = found_bumped;
               if (first_only_ff) begin
                  scan_stopped_in = 1'b1;
               end
            end
         end
      end
   end

   // next result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_count_in  = rsp_count_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            rsp_valid_in  = 1'b1;
            rsp_offset_in = '0;
            rsp_end_in    = 1'b1;
            rsp_count_in  = found_total_ff;
         end else if (match_report) begin
            rsp_valid_in  = 1'b1;
            rsp_offset_in = FIELD_BITS'(cand_start);
            rsp_end_in    = 1'b0;
            rsp_count_in  = found_bumped;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         next_candidate_ff <= '0;
         found_total_ff    <= '0;
         scan_stopped_ff   <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         window_ff         <= '0;
      end else begin
         byte_position_ff  <= byte_position_in;
         next_candidate_ff <= next_candidate_in;
         found_total_ff    <= found_total_in;
         scan_stopped_ff   <= scan_stopped_in;
         rsp_valid_ff      <= rsp_valid_in;
         window_ff         <= window_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = rsp_offset_ff;
   assign rsp_end_of_scan  = rsp_end_ff;
   assign rsp_match_count  = rsp_count_ff;

`ifndef ASSERT_OFF
   // a closing beat restarts the image at position zero
   a_restart_position: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> byte_position_ff == '0)
      else $error("position not cleared after closing beat");

   // a match beat always carries a nonzero count and offset
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_end_ff |-> rsp_count_ff != '0 && rsp_offset_ff != '0)
      else $error("match beat with zero count or offset");

   // the closing beat has offset zero
   a_closing_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> rsp_offset_ff == '0)
      else $error("closing beat with nonzero offset");

   // a stopped scan reports nothing more
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      scan_stopped_ff |-> !match_report)
      else $error("match reported after scan stopped");
`endif

endmodule

`default_nettype wire

// ===== bench/mps_scan_checker.sv =====
// ----------------------------------------------------------------------------
// mps_scan_checker - result checker for the masked pattern scanner
// Watches the byte, result and register ports, keeps its own copy of the
// scan state, predicts the match and closing beats and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_scan_checker
   import mps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic [BYTE_BITS-1:0]      req_data_byte,
   input  wire logic                      req_last_byte,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic [FIELD_BITS-1:0]     rsp_match_offset,
   input  wire logic                      rsp_end_of_scan,
   input  wire logic [FIELD_BITS-1:0]     rsp_match_count,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int                             error_total,
   output int                             awaited_total
);

   localparam int WINDOW_DEPTH = 8;
   localparam int REPORT_LIMIT = 10;
   localparam logic [FIELD_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] match_offset;
      logic                  end_of_scan;
      logic [FIELD_BITS-1:0] match_count;
   } scan_report_type;

   // register copies
   cmp_cfg_type           cmp_cfg;
   logic [LEN_BITS-1:0]   len_reg;
   logic [FIELD_BITS-1:0] start_reg;
   logic                  first_only_reg;

   // scan state
   logic [BYTE_BITS-1:0]  recent [WINDOW_DEPTH];
   logic [FIELD_BITS-1:0] byte_pos;
   logic [FIELD_BITS-1:0] restart_at;
   logic [FIELD_BITS-1:0] hits_found;
   logic                  halted;

   scan_report_type expected_reports [$];

   // clamp the length register into 1..WINDOW_DEPTH
   function automatic int unsigned used_length();
      if (len_reg == '0) return 1;
      if (len_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
      return len_reg;
   endfunction

   // compare the newest n bytes against the pattern under the care mask
   function automatic bit window_hit(input int unsigned n);
      logic [BYTE_BITS-1:0] pat;
      logic [BYTE_BITS-1:0] msk;
      for (int unsigned k = 0; k < n; k++) begin
         pat = cmp_cfg.pattern_bytes[BYTE_BITS*k +: BYTE_BITS];
         msk = cmp_cfg.care_mask[BYTE_BITS*k +: BYTE_BITS];
         if (((recent[n-1-k] ^ pat) & msk) != '0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic restart_scan();
      for (int i = 0; i < WINDOW_DEPTH; i++) recent[i] = '0;
      byte_pos   = '0;
      restart_at = start_reg;
      hits_found = '0;
      halted     = 1'b0;
   endtask

   task automatic apply_reg_write(input logic [CSR_IDX_BITS-1:0] idx,
                                  input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_PATTERN_BYTES:  cmp_cfg.pattern_bytes = data;
         CSR_CARE_MASK:      cmp_cfg.care_mask = data;
         CSR_PATTERN_LENGTH: len_reg = data[LEN_BITS-1:0];
         CSR_START_OFFSET: begin
            start_reg = data[FIELD_BITS-1:0];
            // a new start point only lands at once before the first byte
            if (byte_pos == '0) restart_at = start_reg;
         end
         CSR_FIRST_ONLY:     first_only_reg = data[0];
         default: ;
      endcase
   endtask

   // advance the scan by one image byte and queue any result it causes
   task automatic scan_byte(input logic [BYTE_BITS-1:0] data, input logic last);
      int unsigned           n;
      logic [FIELD_BITS-1:0] p;
      logic [FIELD_BITS-1:0] s;
      scan_report_type       rpt;
      n = used_length();
      p = byte_pos;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = data;

      // a window holding the final byte never matches
      if (!last && !halted && p >= n - 1) begin
         s = p - FIELD_BITS'(n - 1);
         if (s >= restart_at && ((s ^ restart_at) & ALIGN_MASK) == 0 && window_hit(n)) begin
            restart_at = s + FIELD_BITS'(n);
            // a hit at offset zero restarts the scan but is dropped
            if (s != '0) begin
               if (hits_found != COUNT_MAX) hits_found++;
               if (first_only_reg) halted = 1'b1;
               rpt.match_offset = s;
               rpt.end_of_scan  = 1'b0;
               rpt.match_count  = hits_found;
               expected_reports.push_back(rpt);
               byte_pos = p + 1'b1;
               return;
            end
         end
      end

      if (last) begin
         rpt.match_offset = '0;
         rpt.end_of_scan  = 1'b1;
         rpt.match_count  = hits_found;
         expected_reports.push_back(rpt);
         restart_scan();
      end else begin
         byte_pos = p + 1'b1;
      end
   endtask

   // compare one result beat with the oldest prediction
   task automatic check_report();
      scan_report_type want;
      if (expected_reports.size() == 0) begin
         error_total++;
         if (error_total <= REPORT_LIMIT)
            $display("unexpected result beat: offset %0d end %0b count %0d",
                     rsp_match_offset, rsp_end_of_scan, rsp_match_count);
         return;
      end
      want = expected_reports.pop_front();
      if (rsp_match_offset !== want.match_offset || rsp_end_of_scan !== want.end_of_scan ||
          rsp_match_count !== want.match_count) begin
         error_total++;
         if (error_total <= REPORT_LIMIT)
            $display("result beat differs: want offset %0d end %0b count %0d, got %0d %0b %0d",
                     want.match_offset, want.end_of_scan, want.match_count,
                     rsp_match_offset, rsp_end_of_scan, rsp_match_count);
      end
   endtask

   // results first, so a beat leaving this edge is matched before new ones queue
   always @(posedge clock) begin
      if (reset) begin
         cmp_cfg.pattern_bytes = '0;
         cmp_cfg.care_mask     = '1;
         len_reg               = LEN_BITS'(WINDOW_DEPTH);
         start_reg             = '0;
         first_only_reg        = 1'b0;
         restart_scan();
         expected_reports.delete();
         error_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_report();
         if (csr_write_enable) apply_reg_write(csr_index, csr_write_data);
         if (req_valid && req_ready) scan_byte(req_data_byte, req_last_byte);
      end
      awaited_total = expected_reports.size();
   end

endmodule

`default_nettype wire

// ===== bench/tb_masked_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// tb_masked_pattern_scanner_unit - stimulus and verdict for the pattern scanner
// Streams directed and random images, many with planted pattern copies, under
// varied register settings and random stalls; a checker beside the block
// predicts every result beat and counts errors.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_masked_pattern_scanner_unit;
   import mps_pkg::*;

   localparam int WINDOW_DEPTH = 8;
   localparam int ITEM_TARGET  = 1270;
   localparam int CALM_FROM    = 500;
   localparam int CALM_TO      = 760;
   localparam int QUIET_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE     = CSR_FIRST_ONLY + 1'b1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP_INDEX = '1;
   localparam logic [FIELD_BITS-1:0]   START_MAX     = '1;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [BYTE_BITS-1:0]     req_data_byte;
   logic                     req_last_byte;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [FIELD_BITS-1:0]    rsp_match_offset;
   logic                     rsp_end_of_scan;
   logic [FIELD_BITS-1:0]    rsp_match_count;
   logic                     csr_write_enable;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   int error_total;
   int awaited_total;
   int bytes_sent;
   int cycle_count;
   bit calm;

   // register values as last written, used to plant pattern copies
   logic [CSR_DATA_BITS-1:0] cur_pattern;
   logic [CSR_DATA_BITS-1:0] cur_mask;
   logic [LEN_BITS-1:0]      cur_len;

   masked_pattern_scanner_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_offset (rsp_match_offset),
      .rsp_end_of_scan  (rsp_end_of_scan),
      .rsp_match_count  (rsp_match_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mps_scan_checker scan_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_offset (rsp_match_offset),
      .rsp_end_of_scan  (rsp_end_of_scan),
      .rsp_match_count  (rsp_match_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_total      (error_total),
      .awaited_total    (awaited_total)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // stall the result side at random, except in the calm stretch
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 31);
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("masked_pattern_scanner_unit: mismatch");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // keep the low bits, fill the bits the register ignores with noise
   function automatic logic [63:0] padded(input logic [63:0] value, input int unsigned width);
      logic [63:0] keep;
      keep = (64'd1 << width) - 64'd1;
      return (rand_word() & ~keep) | (value & keep);
   endfunction

   function automatic int unsigned pattern_span();
      if (cur_len == '0) return 1;
      if (cur_len > WINDOW_DEPTH) return WINDOW_DEPTH;
      return cur_len;
   endfunction

   // drive one register write; close_writes drops the enable
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic close_writes();
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [63:0] pat, input logic [63:0] mask,
                             input logic [63:0] len_word, input logic [63:0] start_word,
                             input logic [63:0] first_word);
      write_reg(CSR_PATTERN_BYTES, pat);
      write_reg(CSR_CARE_MASK, mask);
      write_reg(CSR_PATTERN_LENGTH, len_word);
      write_reg(CSR_START_OFFSET, start_word);
      write_reg(CSR_FIRST_ONLY, first_word);
      close_writes();
      cur_pattern = pat;
      cur_mask    = mask;
      cur_len     = len_word[LEN_BITS-1:0];
   endtask

   // offer one byte beat, with random idle cycles ahead of it
   task automatic push_byte(input logic [BYTE_BITS-1:0] data, input logic last);
      calm = (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
      while (!calm && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // hold off the sender until every result is out, then let the block settle
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_total != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // build one image of noise and planted pattern copies, then stream it
   task automatic send_image();
      logic [BYTE_BITS-1:0] img [$];
      logic [BYTE_BITS-1:0] msk;
      int unsigned          size;
      int unsigned          span;
      int unsigned          split;
      int unsigned          pick;
      bit                   noisy;
      size  = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      noisy = ($urandom_range(4) == 0);
      while (img.size() < size) begin
         span = pattern_span();
         if (!noisy && $urandom_range(3) == 0) begin
            for (int unsigned k = 0; k < span; k++) begin
               msk = cur_mask[BYTE_BITS*k +: BYTE_BITS];
               img.push_back((cur_pattern[BYTE_BITS*k +: BYTE_BITS] & msk) |
                             (BYTE_BITS'($urandom) & ~msk));
            end
            // break some copies by one bit
            if ($urandom_range(5) == 0) begin
               pick = img.size() - 1 - $urandom_range(span - 1);
               img[pick] = img[pick] ^ (8'd1 << $urandom_range(7));
            end
         end else begin
            img.push_back(BYTE_BITS'($urandom));
         end
      end

      split = ($urandom_range(5) == 0) ? $urandom_range(0, img.size() - 1) : img.size();
      for (int unsigned k = 0; k < img.size(); k++) begin
         // pause mid-image and move the start point, sometimes the pattern too
         if (k == split) begin
            settle();
            write_reg(CSR_START_OFFSET,
                      padded(($urandom_range(3) == 0) ? START_MAX : $urandom_range(0, 9),
                             FIELD_BITS));
            if ($urandom_range(1) == 1) begin
               cur_pattern = rand_word();
               write_reg(CSR_PATTERN_BYTES, cur_pattern);
            end
            close_writes();
         end
         push_byte(img[k], k == img.size() - 1);
      end
   endtask

   initial begin
      logic [63:0]           mask_word;
      logic [LEN_BITS-1:0]   len_pick;
      logic [FIELD_BITS-1:0] start_pick;
      int unsigned           phase;
      int unsigned           roll;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_last_byte    = 1'b0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      calm             = 1'b0;
      bytes_sent       = 0;
      cycle_count      = 0;
      cur_pattern      = '0;
      cur_mask         = '1;
      cur_len          = LEN_BITS'(WINDOW_DEPTH);

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: an all-zero window at offset zero is dropped
      repeat (8) push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      settle();

      // writes to unused indexes must change nothing
      write_reg(CSR_SPARE, '1);
      write_reg(CSR_TOP_INDEX, '1);

      // two-byte pattern: hit at zero dropped, hit at two kept, final window refused
      set_config(64'h00FF, '1, 64'd2, 64'd0, 64'd0);
      repeat (3) begin
         push_byte(8'hFF, 1'b0);
         push_byte(8'h00, bytes_sent == 14);
      end
      settle();

      // length zero, high nibble only, start one, first hit only
      set_config(64'hA5, 64'hF0, 64'd0, 64'd1, 64'd1);
      push_byte(8'hA0, 1'b0);
      push_byte(8'hAF, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h00, 1'b1);
      settle();

      // random phases, the first few at extreme settings
      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         case (phase)
            0: set_config(rand_word(), '1, padded(64'd1, LEN_BITS), padded(64'd0, FIELD_BITS),
                          padded(64'd0, 1));
            1: set_config(rand_word(), '0, padded(64'd8, LEN_BITS), padded(64'd0, FIELD_BITS),
                          padded(64'd0, 1));
            2: set_config(rand_word(), rand_word(), padded(64'd15, LEN_BITS),
                          padded(START_MAX, FIELD_BITS), padded(64'd0, 1));
            3: set_config('1, '1, padded(64'd0, LEN_BITS), padded(64'd3, FIELD_BITS),
                          padded(64'd1, 1));
            4: set_config('0, rand_word(), padded(64'd8, LEN_BITS), padded(64'd2, FIELD_BITS),
                          padded(64'd1, 1));
            default: begin
               roll = $urandom_range(7);
               mask_word = (roll < 4) ? '1 :
                           (roll < 6) ? (rand_word() | rand_word()) :
                           (roll == 6) ? rand_word() : '0;
               len_pick = ($urandom_range(4) == 0) ? LEN_BITS'($urandom_range(0, 15))
                                                   : LEN_BITS'($urandom_range(1, 8));
               roll = $urandom_range(19);
               start_pick = (roll < 15) ? FIELD_BITS'($urandom_range(0, 9)) :
                            (roll < 18) ? FIELD_BITS'($urandom) : START_MAX;
               set_config(rand_word(), mask_word, padded(len_pick, LEN_BITS),
                          padded(start_pick, FIELD_BITS),
                          padded($urandom_range(3) == 0, 1));
            end
         endcase
         repeat ($urandom_range(1, 4)) send_image();
         settle();
         phase++;
      end

      settle();
      if (error_total == 0 && awaited_total == 0)
         $display("masked_pattern_scanner_unit: match");
      else
         $display("masked_pattern_scanner_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
